[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL; included by the controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/colray_pkg.sv]
// Package: shared types, codes and tables of the column raycaster.
`timescale 1ns / 1ps
`default_nettype none
package colray_pkg;

  localparam int SCREEN_WIDTH_DEF  = 120;
  localparam int SCREEN_HEIGHT_DEF = 40;
  localparam int MAP_SIZE          = 16;

  localparam int DIVIDEND_W = 24;
  localparam int DIVISOR_W  = 11;
  localparam int CORDIC_ITERS = 14;

  localparam logic [1:0] CMD_LEFT  = 2'd0;
  localparam logic [1:0] CMD_RIGHT = 2'd1;
  localparam logic [1:0] CMD_CAST  = 2'd2;

  localparam logic [2:0] REG_MAP0  = 3'd0;
  localparam logic [2:0] REG_MAP1  = 3'd1;
  localparam logic [2:0] REG_MAP2  = 3'd2;
  localparam logic [2:0] REG_MAP3  = 3'd3;
  localparam logic [2:0] REG_PX    = 3'd4;
  localparam logic [2:0] REG_PY    = 3'd5;
  localparam logic [2:0] REG_FOV   = 3'd6;
  localparam logic [2:0] REG_STEPS = 3'd7;

  localparam logic [15:0] TURN_STEP = 16'd1043;

  typedef struct packed {
    logic turn_left;
    logic turn_right;
    logic load_item;
    logic div_start;
    logic ang_load;     // column*fov / width by reciprocal multiply
    logic cordic_init;
    logic cordic_step;
    logic sc_load;
    logic march_init;
    logic march_step;
    logic load_out;
  } colray_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cordic_last;
    logic march_end;
    logic out_free;
  } colray_sts_t;

  function automatic logic signed [16:0] atan_bam(input logic [3:0] i);
    logic signed [16:0] v;
    unique case (i)
      4'd0:    v = 17'sd8192;
      4'd1:    v = 17'sd4836;
      4'd2:    v = 17'sd2555;
      4'd3:    v = 17'sd1297;
      4'd4:    v = 17'sd651;
      4'd5:    v = 17'sd326;
      4'd6:    v = 17'sd163;
      4'd7:    v = 17'sd81;
      4'd8:    v = 17'sd41;
      4'd9:    v = 17'sd20;
      4'd10:   v = 17'sd10;
      4'd11:   v = 17'sd5;
      4'd12:   v = 17'sd3;
      4'd13:   v = 17'sd1;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/column_raycaster_top.sv]
// Top level of the column raycaster.
// Turn requests (left, right) give no result. A cast request runs, from acceptance
// to the result, through the ray angle offset by reciprocal multiply, 14 CORDIC
// iterations, the march samples (1 to max_steps, at least one), and a 24-bit
// bit-serial divide for the ceiling row. One request is in flight at a time; a
// finished result sits in the output register and the next request is taken while
// it waits, but a cast that finishes while the old result is still unread holds
// until it is taken. Configuration writes are always ready and take effect at once;
// write them only while no cast is in flight.
`timescale 1ns / 1ps
`default_nettype none
module column_raycaster_top #(
  parameter int SCREEN_WIDTH  = colray_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = colray_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        command,
  input  wire logic [6:0]        column,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [6:0]             column_out,
  output logic signed [9:0]      ceiling_row,
  output logic [8:0]             floor_row,
  output logic [7:0]             distance_steps,
  output logic                   reached_limit,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [63:0]       cfg_data
);
  import colray_pkg::*;

  colray_cmd_t cmd;
  colray_sts_t sts;

  assign cfg_ready = 1'b1;

  colray_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .sts      (sts),
    .cmd      (cmd)
  );

  colray_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .column         (column),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .column_out     (column_out),
    .ceiling_row    (ceiling_row),
    .floor_row      (floor_row),
    .distance_steps (distance_steps),
    .reached_limit  (reached_limit)
  );
endmodule
`default_nettype wire

[hw/rtl/colray_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module colray_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [colray_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [colray_pkg::DIVISOR_W-1:0]  divisor,
  output logic                                   done,
  output logic [colray_pkg::DIVIDEND_W-1:0]      quotient
);
  import colray_pkg::*;

  localparam int CW = $clog2(DIVIDEND_W);
  localparam logic [CW-1:0] LAST = CW'(DIVIDEND_W - 1);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign done  = busy && (cnt == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == LAST) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DIVISOR_W'(trial - {1'b0, dvs}) : trial[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end
endmodule
`default_nettype wire

[hw/rtl/colray_dp.sv]
// Datapath: registers, heading, angle offset, CORDIC, ray march, divider and result register.
`timescale 1ns / 1ps
`default_nettype none
module colray_dp #(
  parameter int SCREEN_WIDTH  = colray_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = colray_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire colray_pkg::colray_cmd_t   cmd,
  output colray_pkg::colray_sts_t        sts,
  input  wire logic                      cfg_write,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [63:0]               cfg_data,
  input  wire logic [6:0]                column,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic [6:0]                     column_out,
  output logic signed [9:0]              ceiling_row,
  output logic [8:0]                     floor_row,
  output logic [7:0]                     distance_steps,
  output logic                           reached_limit
);
  import colray_pkg::*;

  localparam int XW = 24;
  localparam int NW = 25;
  localparam logic signed [11:0] HS = 12'(SCREEN_HEIGHT);

  // column*fov < 2^23; exact floor division by the width through m = ceil(2^s / W)
  localparam int CF_W = 23;
  localparam int WSH  = CF_W + $clog2(SCREEN_WIDTH);
  localparam logic [55:0] RECIP =
    56'(((64'd1 << WSH) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

  logic [63:0] map0, map1, map2, map3;
  logic [11:0] px, py;
  logic [15:0] fov;
  logic [7:0]  max_steps;
  logic [15:0] heading;
  logic [6:0]  col_r;
  logic [CF_W-1:0] cf;
  logic [55:0] prod;
  logic [15:0] ang_off;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      map0      <= 64'd9223794255762423807;
      map1      <= 64'd9223794255762391041;
      map2      <= 64'd9223794255762391041;
      map3      <= 64'd18446603342663745537;
      px        <= 12'd2048;
      py        <= 12'd2048;
      fov       <= 16'd8203;
      max_steps <= 8'd160;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAP0:  map0      <= cfg_data;
        REG_MAP1:  map1      <= cfg_data;
        REG_MAP2:  map2      <= cfg_data;
        REG_MAP3:  map3      <= cfg_data;
        REG_PX:    px        <= cfg_data[11:0];
        REG_PY:    py        <= cfg_data[11:0];
        REG_FOV:   fov       <= cfg_data[15:0];
        REG_STEPS: max_steps <= cfg_data[7:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) heading <= '0;
    else if (cmd.turn_left) heading <= heading - TURN_STEP;
    else if (cmd.turn_right) heading <= heading + TURN_STEP;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      col_r <= column;
      cf    <= CF_W'(column * fov);
    end
  end

  assign prod = 56'(cf) * RECIP;

  always_ff @(posedge clk) begin
    if (cmd.ang_load) ang_off <= prod[WSH +: 16];
  end

  // divider for the ceiling row
  logic [DIVIDEND_W-1:0] div_a;
  logic [DIVISOR_W-1:0]  div_b;
  logic [DIVIDEND_W-1:0] quo;
  logic                  div_done;
  logic [7:0]            hit_dist;
  logic                  at_limit;
  logic signed [9:0]     dist_m20;
  logic signed [21:0]    num;
  logic [21:0]           num_abs;
  logic                  num_neg;

  assign dist_m20 = $signed({2'b00, hit_dist}) - 10'sd20;
  assign num      = HS * dist_m20;
  assign num_abs  = num[21] ? 22'(-num) : 22'(num);
  assign div_a    = {2'b00, num_abs};
  assign div_b    = {2'b00, hit_dist, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_start) num_neg <= num[21];
  end

  colray_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quo)
  );

  // CORDIC rotation over the low 14 angle bits
  logic signed [XW-1:0] cx, cy;
  logic signed [16:0]   cz;
  logic [3:0]           it;
  logic [1:0]           quad;
  logic [15:0]          angle;
  logic signed [XW-1:0] dx, dy;

  assign angle = heading - {1'b0, fov[15:1]} + ang_off;
  assign dx    = cx >>> it;
  assign dy    = cy >>> it;

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      cx   <= XW'(636751);
      cy   <= '0;
      cz   <= $signed({3'b000, angle[13:0]});
      quad <= angle[15:14];
      it   <= '0;
    end else if (cmd.cordic_step) begin
      it <= it + 4'd1;
      if (!cz[16]) begin
        cx <= cx - dy;
        cy <= cy + dx;
        cz <= cz - atan_bam(it);
      end else begin
        cx <= cx + dy;
        cy <= cy - dx;
        cz <= cz + atan_bam(it);
      end
    end
  end

  function automatic logic signed [15:0] to_q14(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = (v + XW'(32)) >>> 6;
    if (t > XW'(16384)) t = XW'(16384);
    if (t < -XW'(16384)) t = -XW'(16384);
    return t[15:0];
  endfunction

  logic signed [15:0] sr, cr, s_q, c_q;
  assign sr = to_q14(cy);
  assign cr = to_q14(cx);

  always_ff @(posedge clk) begin
    if (cmd.sc_load) begin
      unique case (quad)
        2'd0: begin s_q <= sr;  c_q <= cr;  end
        2'd1: begin s_q <= cr;  c_q <= -sr; end
        2'd2: begin s_q <= -sr; c_q <= -cr; end
        default: begin s_q <= -cr; c_q <= sr; end
      endcase
    end
  end

  // ray march: n = p*640 + e*k, cell = trunc(n / 163840)
  logic signed [NW-1:0] nx, ny;
  logic [7:0]           k;
  logic [7:0]           limit;

  function automatic logic [4:0] cell_of(input logic signed [NW-1:0] n);
    logic [6:0]  m;
    logic [14:0] p;
    logic [4:0]  r;
    m = n[21:15];
    p = 15'(m * 8'd205);
    if (n < 0) r = {(n <= -NW'(163840)), 4'd0};
    else if (n >= NW'(2621440)) r = 5'b10000;
    else r = {1'b0, p[13:10]};
    return r;
  endfunction

  logic [4:0]   cellx, celly;
  logic         outside, wall;
  logic [255:0] map_all;

  assign limit   = (max_steps == 8'd0) ? 8'd1 : max_steps;
  assign cellx   = cell_of(nx);
  assign celly   = cell_of(ny);
  assign outside = cellx[4] | celly[4];
  assign map_all = {map3, map2, map1, map0};
  assign wall    = map_all[{celly[3:0], cellx[3:0]}];

  always_ff @(posedge clk) begin
    if (cmd.march_init) begin
      nx <= $signed(NW'(px) * NW'(640)) + NW'(s_q);
      ny <= $signed(NW'(py) * NW'(640)) + NW'(c_q);
      k  <= 8'd1;
    end else if (cmd.march_step) begin
      if (sts.march_end) begin
        at_limit <= outside | ~wall;
        hit_dist <= (!outside && wall) ? k : limit;
      end else begin
        nx <= nx + NW'(s_q);
        ny <= ny + NW'(c_q);
        k  <= k + 8'd1;
      end
    end
  end

  // result register
  logic signed [9:0] ceil_v;
  assign ceil_v = num_neg ? -$signed(quo[9:0]) : $signed(quo[9:0]);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      column_out     <= col_r;
      ceiling_row    <= ceil_v;
      floor_row      <= 9'(SCREEN_HEIGHT) - ceil_v[8:0];
      distance_steps <= hit_dist;
      reached_limit  <= at_limit;
    end
  end

  assign sts.div_done    = div_done;
  assign sts.cordic_last = (it == 4'(CORDIC_ITERS - 1));
  assign sts.march_end   = outside | wall | (k == limit);
  assign sts.out_free    = !out_valid || out_ready;
endmodule
`default_nettype wire

[hw/rtl/colray_ctrl.sv]
// Controller: sequences one request through angle, CORDIC, march and divide.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module colray_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              command,
  input  wire colray_pkg::colray_sts_t sts,
  output colray_pkg::colray_cmd_t      cmd
);
  import colray_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AOFF  = 4'd1;
  localparam logic [3:0] S_ANG   = 4'd2;
  localparam logic [3:0] S_CORD  = 4'd3;
  localparam logic [3:0] S_SC    = 4'd4;
  localparam logic [3:0] S_MINIT = 4'd5;
  localparam logic [3:0] S_MARCH = 4'd6;
  localparam logic [3:0] S_D2S   = 4'd7;
  localparam logic [3:0] S_DIV2  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (command)
            CMD_LEFT:  cmd.turn_left  = 1'b1;
            CMD_RIGHT: cmd.turn_right = 1'b1;
            CMD_CAST: begin
              cmd.load_item = 1'b1;
              state_next    = S_AOFF;
            end
            default: ;
          endcase
        end
      end
      S_AOFF: begin
        cmd.ang_load = 1'b1;
        state_next   = S_ANG;
      end
      S_ANG: begin
        cmd.cordic_init = 1'b1;
        state_next      = S_CORD;
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        if (sts.cordic_last) state_next = S_SC;
      end
      S_SC: begin
        cmd.sc_load = 1'b1;
        state_next  = S_MINIT;
      end
      S_MINIT: begin
        cmd.march_init = 1'b1;
        state_next     = S_MARCH;
      end
      S_MARCH: begin
        cmd.march_step = 1'b1;
        if (sts.march_end) state_next = S_D2S;
      end
      S_D2S: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV2;
      end
      S_DIV2:  if (sts.div_done) state_next = S_FIN;
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  `ASSERT_IMPL(a_div_done_wait, clk, rst, sts.div_done, state == S_DIV2)
  `ASSERT_IMPL(a_load_out_free, clk, rst, cmd.load_out, sts.out_free)
  `ASSERT_NEXT(a_fin_to_idle, clk, rst, state == S_FIN && sts.out_free, state == S_IDLE)
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Testbench for the column raycaster: turn/cast requests checked against a local predictor.
`timescale 1ns / 1ps
module tb_top;
  import colray_pkg::*;

  localparam int W = 120;
  localparam int H = 40;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = '0;
  logic [6:0] column = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [6:0] column_out;
  logic signed [9:0] ceiling_row;
  logic [8:0] floor_row;
  logic [7:0] distance_steps;
  logic reached_limit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  typedef struct packed {
    logic [6:0] col;
    logic [9:0] ceil_r;
    logic [8:0] floor_r;
    logic [7:0] hit_dist;
    logic lim;
  } column_rec_t;

  column_rec_t pending_columns[$];

  // predictor state
  logic [63:0] map_q[4];
  logic [11:0] pos_x, pos_y;
  logic [15:0] fov, head;
  logic [7:0] step_lim;

  int errors = 0;
  int idle_cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 1'b0;

  column_raycaster_top i_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint fshift(longint v, int n);
    if (v >= 0) return v >>> n;
    return -((-v - 1) >>> n) - 1;
  endfunction

  function automatic longint q14(longint v);
    longint q;
    q = fshift(v + 32, 6);
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q;
  endfunction

  function automatic void trig(input logic [15:0] ang, output longint s, output longint c);
    longint x, y, z, dx, dy, cr, sr;
    longint atab[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    x = 636751; y = 0; z = ang[13:0];
    for (int i = 0; i < 14; i++) begin
      dx = fshift(x, i);
      dy = fshift(y, i);
      if (z >= 0) begin
        x -= dy; y += dx; z -= atab[i];
      end else begin
        x += dy; y -= dx; z += atab[i];
      end
    end
    cr = q14(x);
    sr = q14(y);
    case (ang[15:14])
      2'd0: begin s = sr; c = cr; end
      2'd1: begin s = cr; c = -sr; end
      2'd2: begin s = -sr; c = -cr; end
      default: begin s = -cr; c = sr; end
    endcase
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [63:0] v);
    case (idx)
      REG_MAP0, REG_MAP1, REG_MAP2, REG_MAP3: map_q[idx[1:0]] = v;
      REG_PX: pos_x = v[11:0];
      REG_PY: pos_y = v[11:0];
      REG_FOV: fov = v[15:0];
      default: step_lim = v[7:0];
    endcase
  endfunction

  // Apply one request to the predictor; queue a column result for a cast.
  function automatic void predict_column(logic [1:0] cmd, logic [6:0] col);
    int lim, k, hit_dist;
    logic [15:0] ang;
    longint s, c, px, py, cx, cy;
    int ceil_i, floor_i;
    bit at_lim;
    column_rec_t r;
    if (cmd == CMD_LEFT) begin
      head = head - TURN_STEP;
      return;
    end
    if (cmd == CMD_RIGHT) begin
      head = head + TURN_STEP;
      return;
    end
    if (cmd != CMD_CAST) return;
    lim = (step_lim != 0) ? int'(step_lim) : 1;
    ang = 16'(head - (fov >> 1) + (int'(col) * int'(fov)) / W);
    trig(ang, s, c);
    px = longint'(pos_x) * 163840;
    py = longint'(pos_y) * 163840;
    at_lim = 1'b1;
    hit_dist = 0;
    for (k = 1; k <= lim; k++) begin
      cx = (px + s * longint'(k) * 256) / 41943040;
      cy = (py + c * longint'(k) * 256) / 41943040;
      if (cx < 0 || cx >= 16 || cy < 0 || cy >= 16) break;
      if (map_q[cy[3:2]][cy[1:0] * 16 + cx[3:0]]) begin
        hit_dist = k; at_lim = 1'b0; break;
      end
    end
    if (at_lim) hit_dist = lim;
    ceil_i = (H * hit_dist - 20 * H) / (2 * hit_dist);
    floor_i = H - ceil_i;
    r.col = col;
    r.ceil_r = ceil_i[9:0];
    r.floor_r = floor_i[8:0];
    r.hit_dist = hit_dist[7:0];
    r.lim = at_lim;
    pending_columns.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    column_rec_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_columns.size() == 0) begin
        report_mismatch("unexpected result, column", column_out, -1);
      end else begin
        e = pending_columns.pop_front();
        if (column_out !== e.col) report_mismatch("column_out", column_out, e.col);
        if (ceiling_row !== e.ceil_r)
          report_mismatch("ceiling_row", ceiling_row, $signed(e.ceil_r));
        if (floor_row !== e.floor_r) report_mismatch("floor_row", floor_row, e.floor_r);
        if (distance_steps !== e.hit_dist)
          report_mismatch("distance_steps", distance_steps, e.hit_dist);
        if (reached_limit !== e.lim)
          report_mismatch("reached_limit", reached_limit, e.lim);
      end
    end
  end

  // receiver ready, with random stalls and a long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        rst || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] cmd, logic [6:0] col);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_valid <= 1'b1;
    command <= cmd;
    column <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_column(cmd, col);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // registers change only while no cast is in flight
  task automatic cfg_write(logic [2:0] idx, logic [63:0] v);
    while (pending_columns.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    write_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_request(CMD_CAST, 7'd0);
    send_request(CMD_CAST, 7'd119);
    send_request(CMD_CAST, 7'd127);
    send_request(CMD_LEFT, 7'd127);
    send_request(CMD_CAST, 7'd60);
    send_request(CMD_RIGHT, 7'd0);
    send_request(CMD_RIGHT, 7'd0);
    send_request(CMD_CAST, 7'd60);
    send_request(2'd3, 7'd5);
    send_request(CMD_CAST, 7'd85);
    drain();
    // open and full map, step limit at both ends, zero limit, player at corners, fov extremes
    cfg_write(REG_MAP0, 64'd0);
    cfg_write(REG_MAP1, 64'd0);
    cfg_write(REG_MAP2, 64'd0);
    cfg_write(REG_MAP3, 64'd0);
    cfg_write(REG_STEPS, 64'd255);
    send_request(CMD_CAST, 7'd10);
    cfg_write(REG_PX, 64'd0);
    cfg_write(REG_PY, 64'd0);
    send_request(CMD_CAST, 7'd0);
    drain();
    cfg_write(REG_STEPS, 64'd0);
    cfg_write(REG_PX, 64'hFFF);
    cfg_write(REG_PY, 64'hFFF);
    cfg_write(REG_FOV, 64'd32768);
    send_request(CMD_CAST, 7'd119);
    drain();
    cfg_write(REG_STEPS, 64'd1);
    cfg_write(REG_MAP0, '1);
    cfg_write(REG_MAP1, '1);
    cfg_write(REG_MAP2, '1);
    cfg_write(REG_MAP3, '1);
    cfg_write(REG_FOV, 64'hFFFF);
    send_request(CMD_CAST, 7'd64);
    cfg_write(REG_FOV, 64'd0);
    send_request(CMD_CAST, 7'd3);
    drain();
  endtask

  task automatic random_config();
    cfg_write(REG_MAP0, rand64() & rand64());
    cfg_write(REG_MAP1, rand64() & rand64() & rand64());
    cfg_write(REG_MAP2, rand64() & rand64());
    cfg_write(REG_MAP3, rand64() & rand64() & rand64());
    cfg_write(REG_PX, $urandom_range(4095));
    cfg_write(REG_PY, $urandom_range(4095));
    cfg_write(REG_FOV, ($urandom_range(3) == 0) ? $urandom_range(65535) :
                       $urandom_range(32768));
    cfg_write(REG_STEPS, ($urandom_range(3) == 0) ? $urandom_range(255) :
                         $urandom_range(60));
  endtask

  task automatic random_batch(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 15) send_request(CMD_LEFT, 7'($urandom));
      else if (r < 30) send_request(CMD_RIGHT, 7'($urandom));
      else if (r < 33) send_request(2'd3, 7'($urandom));
      else send_request(CMD_CAST, (r < 36) ? 7'($urandom) : 7'($urandom_range(119)));
    end
    drain();
  endtask

  task automatic test_random_phases();
    int pattern[4][2] = '{'{0, 0}, '{53, 0}, '{0, 53}, '{36, 36}};
    for (int p = 0; p < 8; p++) begin
      send_idle = pattern[p % 4][0];
      recv_stall = pattern[p % 4][1];
      random_config();
      random_batch(60);
    end
    send_idle = 0;
    recv_stall = 0;
  endtask

  task automatic test_backpressure();
    cfg_write(REG_STEPS, 64'd20);
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 10; i++) send_request(CMD_CAST, 7'($urandom_range(119)));
    join
    drain();
  endtask

  initial begin
    for (int i = 0; i < 4; i++) map_q[i] = '0;
    map_q[0] = 64'd9223794255762423807;
    map_q[1] = 64'd9223794255762391041;
    map_q[2] = 64'd9223794255762391041;
    map_q[3] = 64'd18446603342663745537;
    pos_x = 12'd2048;
    pos_y = 12'd2048;
    fov = 16'd8203;
    step_lim = 8'd160;
    head = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/colray_pkg.sv
hw/rtl/colray_div.sv
hw/rtl/colray_dp.sv
hw/rtl/colray_ctrl.sv
hw/rtl/column_raycaster_top.sv
tb/tb_top.sv
